// File: rtl/signed_vector_angle_about_axis_unit_assert.svh
// Assertion macros for the signed vector angle unit checker.
`ifndef SIGNED_VECTOR_ANGLE_ABOUT_AXIS_UNIT_ASSERT_SVH
`define SIGNED_VECTOR_ANGLE_ABOUT_AXIS_UNIT_ASSERT_SVH
// Implication checked in the same cycle, ignored while in reset.
`define SVAU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svau assertion failed");
// Implication checked in the following cycle, also active during reset.
`define SVAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("svau assertion failed");
`endif

// File: rtl/svau_pkg.sv
// Package with types, widths and the arctangent table of the signed vector angle unit.
`timescale 1ns / 1ps
`default_nettype none
package svau_pkg;
  localparam int CompWidth  = 16;
  localparam int AngleWidth = 16;
  localparam int TurnWidth  = 32;
  localparam int ProdWidth  = 2 * CompWidth;
  localparam int CrossWidth = ProdWidth + 1;
  localparam int DotWidth   = ProdWidth + 2;
  localparam int MagWidth   = ProdWidth;
  localparam int SqWidth    = 2 * MagWidth;
  localparam int KzWidth    = CrossWidth + CompWidth + 2;
  localparam int RootWidth  = SqWidth / 2;
  localparam int RemWidth   = RootWidth + 4;
  localparam int XyWidth    = DotWidth + 6;
  localparam int MaxSteps   = 32;

  localparam logic [TurnWidth-1:0] QuarterTurn = 32'h4000_0000;
  localparam logic [TurnWidth-1:0] HalfTurn    = 32'h8000_0000;

  typedef logic signed [CompWidth-1:0] comp_t;

  typedef struct packed {
    comp_t first_x;
    comp_t first_y;
    comp_t first_z;
    comp_t second_x;
    comp_t second_y;
    comp_t second_z;
    comp_t ref_x;
    comp_t ref_y;
    comp_t ref_z;
  } in_word_t;

  typedef struct packed {
    logic [DotWidth-1:0] c_mag;
    logic                cos_zero;
    logic                cos_neg;
    logic                both_nz;
    logic                kz_neg;
    logic                sin_zero;
  } side_t;

  function automatic logic [TurnWidth-1:0] atan_turn(input logic [4:0] idx);
    logic [TurnWidth-1:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// File: rtl/svau_if.sv
// Handshake interfaces for the input and result words of the signed vector angle unit.
`timescale 1ns / 1ps
`default_nettype none
interface svau_in_if;
  import svau_pkg::*;
  logic  valid;
  logic  ready;
  comp_t first_x;
  comp_t first_y;
  comp_t first_z;
  comp_t second_x;
  comp_t second_y;
  comp_t second_z;
  comp_t ref_x;
  comp_t ref_y;
  comp_t ref_z;
  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  ref_x, ref_y, ref_z, input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                ref_x, ref_y, ref_z, output ready);
endinterface

interface svau_out_if;
  import svau_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [AngleWidth-1:0] turn_angle;
  modport source (output valid, turn_angle, input ready);
  modport sink (input valid, turn_angle, output ready);
endinterface
`default_nettype wire

// File: rtl/signed_vector_angle_about_axis_unit.sv
// Top level of the signed vector angle unit: pipeline chain and output word register.
//
// Channel   Direction  Payload
// in_word   sink       first_x..ref_z, nine signed 16-bit components
// out_word  source     turn_angle, unsigned 16-bit fraction of a turn
//
// One word enters per cycle while the output word is not waiting; the pipeline is four product
// stages, 32 square-root stages, one quadrant stage, the CORDIC stages and the output register.
// Reset is synchronous and active low and clears only the valid bits.
// When the output word waits, the whole pipeline holds and in_word.ready drops.
`timescale 1ns / 1ps
`default_nettype none
module signed_vector_angle_about_axis_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input wire logic   clk,
  input wire logic   rst_n,
  svau_in_if.sink    in_word,
  svau_out_if.source out_word
);
  import svau_pkg::*;

  logic                  en;
  in_word_t              in_data;
  logic                  f_valid, q_valid, c_valid;
  logic [SqWidth-1:0]    f_sq;
  logic [RootWidth-1:0]  q_root;
  logic [TurnWidth-1:0]  c_z;
  side_t                 f_side, q_side, c_side;
  logic [TurnWidth-1:0]  ang, signed_ang;
  logic [TurnWidth:0]    rounded;
  logic                  out_valid_r;
  logic [AngleWidth-1:0] out_turn_r;

  assign en = !out_valid_r || out_word.ready;
  assign in_word.ready = en;

  assign in_data = '{first_x: in_word.first_x, first_y: in_word.first_y,
                     first_z: in_word.first_z, second_x: in_word.second_x,
                     second_y: in_word.second_y, second_z: in_word.second_z,
                     ref_x: in_word.ref_x, ref_y: in_word.ref_y, ref_z: in_word.ref_z};

  svau_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_word.valid), .in_data(in_data),
    .out_valid(f_valid), .out_sq(f_sq), .out_side(f_side)
  );

  svau_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(f_valid), .in_sq(f_sq), .in_side(f_side),
    .out_valid(q_valid), .out_root(q_root), .out_side(q_side)
  );

  svau_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(q_valid), .in_root(q_root),
    .in_side(q_side), .out_valid(c_valid), .out_z(c_z), .out_side(c_side)
  );

  always_comb begin
    if (c_side.cos_zero) begin
      ang = c_side.both_nz ? QuarterTurn : '0;
    end else if (c_side.sin_zero) begin
      ang = c_side.cos_neg ? HalfTurn : '0;
    end else begin
      ang = c_z;
    end
    signed_ang = c_side.kz_neg ? ('0 - ang) : ang;
    rounded = {1'b0, signed_ang} + ((TurnWidth+1)'(1) << (TurnWidth - AngleWidth - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_turn_r <= rounded[TurnWidth-1 -: AngleWidth];
    end
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.turn_angle = out_turn_r;
endmodule
`default_nettype wire

// File: rtl/svau_front.sv
// Four-stage front end: products, dot and cross terms, squares and the reference sign.
`timescale 1ns / 1ps
`default_nettype none
module svau_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire svau_pkg::in_word_t       in_data,
  output logic                          out_valid,
  output logic [svau_pkg::SqWidth-1:0]  out_sq,
  output svau_pkg::side_t               out_side
);
  import svau_pkg::*;

  logic signed [ProdWidth-1:0]  p_r [9];
  logic                         s1_v_r, a_nz_r, b_nz_r;
  comp_t                        r1_r [3];

  logic signed [DotWidth-1:0]   dot_r;
  logic signed [CrossWidth-1:0] n_r [3];
  logic                         s2_v_r, s2_both_r;
  comp_t                        r2_r [3];

  logic [SqWidth-1:0]           sq_r [3];
  logic signed [KzWidth-1:0]    nr_r [3];
  logic signed [DotWidth-1:0]   dot3_r;
  logic                         s3_v_r, s3_both_r;

  logic [SqWidth-1:0]           sq_sum_r;
  side_t                        side_r;
  logic                         s4_v_r;

  logic signed [CrossWidth-1:0] n_mag [3];
  logic signed [KzWidth-1:0]    kz_sum;
  logic signed [DotWidth-1:0]   c_abs;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_mag[k] = n_r[k][CrossWidth-1] ? -n_r[k] : n_r[k];
    end
    kz_sum = nr_r[0] + nr_r[1] + nr_r[2];
    c_abs  = dot3_r[DotWidth-1] ? -dot3_r : dot3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= ProdWidth'(in_data.first_x * in_data.second_x);
      p_r[1] <= ProdWidth'(in_data.first_y * in_data.second_y);
      p_r[2] <= ProdWidth'(in_data.first_z * in_data.second_z);
      p_r[3] <= ProdWidth'(in_data.first_y * in_data.second_z);
      p_r[4] <= ProdWidth'(in_data.first_z * in_data.second_y);
      p_r[5] <= ProdWidth'(in_data.first_z * in_data.second_x);
      p_r[6] <= ProdWidth'(in_data.first_x * in_data.second_z);
      p_r[7] <= ProdWidth'(in_data.first_x * in_data.second_y);
      p_r[8] <= ProdWidth'(in_data.first_y * in_data.second_x);
      a_nz_r <= (in_data.first_x != '0) || (in_data.first_y != '0) || (in_data.first_z != '0);
      b_nz_r <= (in_data.second_x != '0) || (in_data.second_y != '0) ||
                (in_data.second_z != '0);
      r1_r[0] <= in_data.ref_x;
      r1_r[1] <= in_data.ref_y;
      r1_r[2] <= in_data.ref_z;

      dot_r <= DotWidth'(p_r[0]) + DotWidth'(p_r[1]) + DotWidth'(p_r[2]);
      n_r[0] <= CrossWidth'(p_r[3]) - CrossWidth'(p_r[4]);
      n_r[1] <= CrossWidth'(p_r[5]) - CrossWidth'(p_r[6]);
      n_r[2] <= CrossWidth'(p_r[7]) - CrossWidth'(p_r[8]);
      s2_both_r <= a_nz_r && b_nz_r;
      r2_r <= r1_r;

      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= SqWidth'(n_mag[k][MagWidth-1:0]) * SqWidth'(n_mag[k][MagWidth-1:0]);
        nr_r[k] <= KzWidth'(n_r[k]) * KzWidth'(r2_r[k]);
      end
      dot3_r    <= dot_r;
      s3_both_r <= s2_both_r;

      sq_sum_r        <= sq_r[0] + sq_r[1] + sq_r[2];
      side_r.c_mag    <= c_abs;
      side_r.cos_zero <= (dot3_r == '0);
      side_r.cos_neg  <= dot3_r[DotWidth-1];
      side_r.both_nz  <= s3_both_r;
      side_r.kz_neg   <= kz_sum[KzWidth-1];
      side_r.sin_zero <= 1'b0;
    end
  end

  assign out_valid = s4_v_r;
  assign out_sq    = sq_sum_r;
  assign out_side  = side_r;
endmodule
`default_nettype wire

// File: rtl/svau_isqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module svau_isqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [svau_pkg::SqWidth-1:0] in_sq,
  input  wire svau_pkg::side_t            in_side,
  output logic                            out_valid,
  output logic [svau_pkg::RootWidth-1:0]  out_root,
  output svau_pkg::side_t                 out_side
);
  import svau_pkg::*;

  logic [RemWidth-1:0]  rem_r  [RootWidth];
  logic [RootWidth-1:0] root_r [RootWidth];
  logic [SqWidth-1:0]   n_r    [RootWidth];
  side_t                side_r [RootWidth];
  logic [RootWidth-1:0] v_r;

  for (genvar k = 0; k < RootWidth; k++) begin : g_stage
    logic [RemWidth-1:0]  rem_in, trial, test;
    logic [RootWidth-1:0] root_in;
    logic [SqWidth-1:0]   n_in;
    logic                 v_in;
    side_t                side_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = in_sq;
      assign v_in    = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign n_in    = n_r[k-1];
      assign v_in    = v_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign trial = {rem_in[RemWidth-3:0], n_in[SqWidth-1 -: 2]};
    assign test  = RemWidth'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]    <= {n_in[SqWidth-3:0], 2'b00};
        side_r[k] <= side_in;
        if (trial >= test) begin
          rem_r[k]  <= trial - test;
          root_r[k] <= {root_in[RootWidth-2:0], 1'b1};
        end else begin
          rem_r[k]  <= trial;
          root_r[k] <= {root_in[RootWidth-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_r[RootWidth-1];
  assign out_root  = root_r[RootWidth-1];
  assign out_side  = side_r[RootWidth-1];
endmodule
`default_nettype wire

// File: rtl/svau_cordic.sv
// Unrolled vectoring CORDIC, one register stage per rotation, after a quadrant stage.
`timescale 1ns / 1ps
`default_nettype none
module svau_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [svau_pkg::RootWidth-1:0] in_root,
  input  wire svau_pkg::side_t              in_side,
  output logic                              out_valid,
  output logic [svau_pkg::TurnWidth-1:0]    out_z,
  output svau_pkg::side_t                   out_side
);
  import svau_pkg::*;

  localparam int Steps = (CORDIC_STEPS < MaxSteps) ? CORDIC_STEPS : MaxSteps;

  logic signed [XyWidth-1:0] x_r [Steps+1];
  logic signed [XyWidth-1:0] y_r [Steps+1];
  logic [TurnWidth-1:0]      z_r [Steps+1];
  side_t                     side_r [Steps+1];
  logic [Steps:0]            v_r;
  side_t                     side_q;

  always_comb begin
    side_q          = in_side;
    side_q.sin_zero = (in_root == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_q;
      if (in_side.cos_neg) begin
        x_r[0] <= XyWidth'(in_root);
        y_r[0] <= XyWidth'(in_side.c_mag);
        z_r[0] <= QuarterTurn;
      end else begin
        x_r[0] <= XyWidth'(in_side.c_mag);
        y_r[0] <= XyWidth'(in_root);
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_rot
    logic signed [XyWidth-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i+1] <= side_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + atan_turn(5'(i));
        end else if (y_r[i] < 0) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - atan_turn(5'(i));
        end else begin
          x_r[i+1] <= x_r[i];
          y_r[i+1] <= y_r[i];
          z_r[i+1] <= z_r[i];
        end
      end
    end
  end

  assign out_valid = v_r[Steps];
  assign out_z     = z_r[Steps];
  assign out_side  = side_r[Steps];
endmodule
`default_nettype wire

// File: rtl/svau_checker.sv
// Port-level checker for the signed vector angle unit and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "signed_vector_angle_about_axis_unit_assert.svh"
module svau_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);
  `SVAU_ASSERT_NOW(a_out_word_held, out_valid && !out_ready, ##1 out_valid)
  `SVAU_ASSERT_NOW(a_stall_blocks_input, out_valid && !out_ready, !in_ready)
  `SVAU_ASSERT_NOW(a_drain_opens_input, !out_valid || out_ready, in_ready)
  `SVAU_ASSERT_NEXT(a_reset_empties_output, !rst_n, !out_valid)
endmodule

bind signed_vector_angle_about_axis_unit svau_checker u_svau_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_word.ready),
  .out_valid(out_word.valid), .out_ready(out_word.ready)
);
`default_nettype wire
